// File: design/tlgs_pkg.sv
// Shared constants, opcodes and cell control type for the toroidal life grid stepper.
package tlgs_pkg;

    localparam int GRID_ROWS_DEF = 16;
    localparam int GRID_COLS_DEF = 32;

    localparam int OPCODE_W   = 2;
    localparam int ROW_IDX_W  = 4;
    localparam int ROW_BITS_W = 32;
    localparam int TDATA_W    = 40;

    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_STEP  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctrl;

endpackage

// File: design/tlgs_cell.sv
// One row cell of the grid chain: loads a written row or takes its neighbor's row on a shift.
module tlgs_cell #(
    parameter int GRID_COLS = tlgs_pkg::GRID_COLS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tlgs_pkg::t_cell_ctrl   i_ctrl,
    input  logic [GRID_COLS-1:0]   i_shift_row,
    input  logic [GRID_COLS-1:0]   i_load_row,
    output logic [GRID_COLS-1:0]   o_row
);
    import tlgs_pkg::*;

    logic [GRID_COLS-1:0] r_row;
    logic [GRID_COLS-1:0] n_row;

    always_comb begin
        n_row = r_row;
        if (i_ctrl.shift) begin
            n_row = i_shift_row;
        end else if (i_ctrl.load) begin
            n_row = i_load_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    assign o_row = r_row;

endmodule

// File: design/tlgs_rule.sv
// B3/S23 next-row logic for one row from its upper, own and lower rows with column wrap.
module tlgs_rule #(
    parameter int GRID_COLS = tlgs_pkg::GRID_COLS_DEF
) (
    input  logic [GRID_COLS-1:0] i_up,
    input  logic [GRID_COLS-1:0] i_mid,
    input  logic [GRID_COLS-1:0] i_dn,
    output logic [GRID_COLS-1:0] o_next
);
    import tlgs_pkg::*;

    for (genvar c = 0; c < GRID_COLS; c++) begin : g_col
        localparam int Lf = (c > 0) ? c - 1 : GRID_COLS - 1;
        localparam int Rt = (c + 1 < GRID_COLS) ? c + 1 : 0;
        logic [3:0] w_count;

        assign w_count = 4'(i_up[Lf]) + 4'(i_up[c]) + 4'(i_up[Rt])
                       + 4'(i_mid[Lf]) + 4'(i_mid[Rt])
                       + 4'(i_dn[Lf]) + 4'(i_dn[c]) + 4'(i_dn[Rt]);
        assign o_next[c] = (w_count == BIRTH_COUNT) ||
                           ((w_count == SURVIVE_COUNT) && i_mid[c]);
    end

endmodule

// File: design/toroidal_life_grid_stepper.sv
// Top level of the toroidal life grid stepper: row cell chain, rule unit and request control.
//
//   channel  | direction | tuser          | tdata (low bit up)
//   s_axis   | in        | opcode [1:0]   | row_index [3:0], row_bits [35:4], zero [39:36]
//   m_axis   | out       | -              | row_index_res [3:0], row_bits_res [35:4], zero [39:36]
//
// Write and read requests are taken while idle; a read result sits in an output register.
// A step holds tready low until its last row is done: the row chain rotates once,
// one row through the rule unit per cycle, with the new row entering the tail cell.
// Synchronous active-low reset clears all cells to dead and empties the output register.
// Any request waits while the output register holds a result that is not taken that cycle.
module toroidal_life_grid_stepper #(
    parameter int GRID_ROWS = tlgs_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = tlgs_pkg::GRID_COLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // row_index [3:0], row_bits [35:4], zero pad [39:36]
    input  logic [tlgs_pkg::TDATA_W-1:0]   i_s_axis_tdata,
    // opcode [1:0]
    input  logic [tlgs_pkg::OPCODE_W-1:0]  i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // row_index_res [3:0], row_bits_res [35:4], zero pad [39:36]
    output logic [tlgs_pkg::TDATA_W-1:0]   o_m_axis_tdata
);
    import tlgs_pkg::*;

    localparam int CntW = $clog2(GRID_ROWS);
    localparam logic [CntW-1:0] CntLast = CntW'(GRID_ROWS - 1);

    typedef enum logic {
        ST_IDLE,
        ST_STEP
    } t_state;

    t_state                 r_state;
    logic [CntW-1:0]        r_cnt;
    logic [GRID_COLS-1:0]   r_prev;
    logic [GRID_COLS-1:0]   r_first;
    logic                   r_out_valid;
    logic [ROW_IDX_W-1:0]   r_out_idx;
    logic [ROW_BITS_W-1:0]  r_out_bits;

    logic [GRID_COLS-1:0]   w_row [GRID_ROWS];
    logic [GRID_COLS-1:0]   w_up;
    logic [GRID_COLS-1:0]   w_dn;
    logic [GRID_COLS-1:0]   w_next;
    logic [GRID_COLS-1:0]   w_load_row;
    logic [GRID_COLS-1:0]   w_sel_row;
    logic [ROW_IDX_W-1:0]   w_idx;
    logic [ROW_BITS_W-1:0]  w_bits;
    logic                   w_accept;
    logic                   w_stepping;

    assign w_idx      = i_s_axis_tdata[ROW_IDX_W-1:0];
    assign w_bits     = i_s_axis_tdata[ROW_IDX_W+ROW_BITS_W-1:ROW_IDX_W];
    assign w_load_row = GRID_COLS'(w_bits);
    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_stepping = (r_state == ST_STEP);

    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_valid || i_m_axis_tready);

    assign w_up = (r_cnt == '0) ? w_row[GRID_ROWS-1] : r_prev;
    assign w_dn = (r_cnt == CntLast) ? r_first : w_row[1];

    tlgs_rule #(
        .GRID_COLS (GRID_COLS)
    ) u_rule (
        .i_up   (w_up),
        .i_mid  (w_row[0]),
        .i_dn   (w_dn),
        .o_next (w_next)
    );

    for (genvar j = 0; j < GRID_ROWS; j++) begin : g_cell
        t_cell_ctrl           w_ctrl;
        logic [GRID_COLS-1:0] w_shift_row;

        assign w_ctrl.shift = w_stepping;
        assign w_ctrl.load  = w_accept && (i_s_axis_tuser == OP_WRITE) &&
                              (32'(w_idx) == 32'(j));
        if (j == GRID_ROWS - 1) begin : g_tail
            assign w_shift_row = w_next;
        end else begin : g_body
            assign w_shift_row = w_row[j+1];
        end

        tlgs_cell #(
            .GRID_COLS (GRID_COLS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_shift_row (w_shift_row),
            .i_load_row  (w_load_row),
            .o_row       (w_row[j])
        );
    end

    always_comb begin
        w_sel_row = '0;
        for (int j = 0; j < GRID_ROWS; j++) begin
            if (32'(w_idx) == 32'(j)) begin
                w_sel_row = w_row[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && (i_s_axis_tuser == OP_READ)) begin
                r_out_valid <= 1'b1;
                r_out_idx   <= w_idx;
                r_out_bits  <= ROW_BITS_W'(w_sel_row);
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_s_axis_tuser == OP_STEP)) begin
                        r_state <= ST_STEP;
                        r_cnt   <= '0;
                    end
                end
                ST_STEP: begin
                    r_prev <= w_row[0];
                    if (r_cnt == '0) begin
                        r_first <= w_row[0];
                    end
                    if (r_cnt == CntLast) begin
                        r_state <= ST_IDLE;
                        r_cnt   <= '0;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(TDATA_W - ROW_IDX_W - ROW_BITS_W)'(0), r_out_bits, r_out_idx};

    a_no_request_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP) |-> !o_s_axis_tready)
        else $error("request taken during a step");

    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_s_axis_tuser == OP_READ)) |=> o_m_axis_tvalid)
        else $error("read request gave no result");

    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_s_axis_tuser == OP_STEP)) |=> ((r_state == ST_STEP) && (r_cnt == '0)))
        else $error("step did not start at row zero");

    a_step_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_STEP) && (r_cnt != CntLast)) |=>
        ((r_state == ST_STEP) && (r_cnt == $past(r_cnt) + 1'b1)))
        else $error("step row counter skipped");

    a_step_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_STEP) && (r_cnt == CntLast)) |=> (r_state == ST_IDLE))
        else $error("step ran past the last row");

endmodule
